FILE: hdl/swm_pkg.sv
package swm_pkg;

  localparam int MaxWindow = 2048;
  localparam int SampleW   = 16;
  localparam int CfgW      = 12;
  localparam int SumW      = 40;
  localparam int IdxW      = $clog2(MaxWindow);
  localparam int CntW      = $clog2(MaxWindow + 1);
  localparam int ResetWindow = 3;

  // Fan-in of each registered level of the median select tree.
  localparam int Fan = 16;
  localparam int L1N = (MaxWindow + Fan - 1) / Fan;
  localparam int L2N = (L1N + Fan - 1) / Fan;

  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

  // One slot of the sorted row. An empty slot orders above every sample.
  typedef struct packed {
    logic               vld;
    logic [SampleW-1:0] val;
  } cell_t;

  // Per-beat command broadcast to every cell of the row.
  typedef struct packed {
    logic               en;
    logic               clr;
    logic               full;
    logic               s_ge_x;
    logic [SampleW-1:0] s;
    logic [SampleW-1:0] x;
  } bcast_t;

endpackage

FILE: hdl/swm_cell.sv
module swm_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            first_i,
  input  swm_pkg::bcast_t cmd_i,
  input  swm_pkg::cell_t  left_i,
  input  swm_pkg::cell_t  right_i,
  output swm_pkg::cell_t  cell_o
);

  logic                        vld_q;
  logic [swm_pkg::SampleW-1:0] val_q;
  swm_pkg::cell_t              nxt;

  logic own_gt_s;
  logic own_ge_x;
  logic left_le_s;
  logic left_lt_x;
  logic right_le_s;

  assign own_gt_s   = !vld_q || (val_q > cmd_i.s);
  assign own_ge_x   = !vld_q || (val_q >= cmd_i.x);
  assign left_le_s  = first_i || (left_i.vld && (left_i.val <= cmd_i.s));
  assign left_lt_x  = first_i || (left_i.vld && (left_i.val < cmd_i.x));
  assign right_le_s = right_i.vld && (right_i.val <= cmd_i.s);

  always_comb begin
    nxt.vld = vld_q;
    nxt.val = val_q;
    if (!cmd_i.full) begin
      // Filling: everything above the insertion point moves up one slot.
      if (own_gt_s) begin
        if (left_le_s) begin
          nxt.vld = 1'b1;
          nxt.val = cmd_i.s;
        end else begin
          nxt = left_i;
        end
      end
    end else if (cmd_i.s_ge_x) begin
      // The new sample lands above the departing one: the gap closes downward.
      if (own_ge_x) begin
        if (right_le_s) begin
          nxt = right_i;
        end else if (!own_gt_s) begin
          nxt.vld = 1'b1;
          nxt.val = cmd_i.s;
        end
      end
    end else begin
      // The new sample lands below the departing one: the gap opens upward.
      if (own_gt_s && left_lt_x) begin
        if (left_le_s) begin
          nxt.vld = 1'b1;
          nxt.val = cmd_i.s;
        end else begin
          nxt = left_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (cmd_i.clr) begin
      vld_q <= 1'b0;
    end else if (cmd_i.en) begin
      vld_q <= nxt.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.en) begin
      val_q <= nxt.val;
    end
  end

  assign cell_o.vld = vld_q;
  assign cell_o.val = val_q;

endmodule

FILE: hdl/swm_chain.sv
module swm_chain (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  swm_pkg::bcast_t             cmd_i,
  input  logic [swm_pkg::IdxW-1:0]    mid_i,
  output logic [swm_pkg::SampleW-1:0] tap_o [swm_pkg::MaxWindow]
);

  swm_pkg::cell_t cells [swm_pkg::MaxWindow];
  swm_pkg::cell_t lefts [swm_pkg::MaxWindow];
  swm_pkg::cell_t rights[swm_pkg::MaxWindow];

  for (genvar k = 0; k < swm_pkg::MaxWindow; k++) begin : g_cell
    if (k == 0) begin : g_lo
      assign lefts[k] = '0;
    end else begin : g_lo
      assign lefts[k] = cells[k-1];
    end
    if (k == swm_pkg::MaxWindow - 1) begin : g_hi
      assign rights[k] = '0;
    end else begin : g_hi
      assign rights[k] = cells[k+1];
    end

    swm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .first_i (k == 0),
      .cmd_i   (cmd_i),
      .left_i  (lefts[k]),
      .right_i (rights[k]),
      .cell_o  (cells[k])
    );

    // Only the slot at the median rank drives its value into the select tree.
    assign tap_o[k] = (mid_i == swm_pkg::IdxW'(k)) ? cells[k].val : '0;
  end

endmodule

FILE: hdl/swm_tree.sv
module swm_tree (
  input  logic                        clk_i,
  input  logic                        adv_i,
  input  logic [swm_pkg::SampleW-1:0] tap_i [swm_pkg::MaxWindow],
  output logic [swm_pkg::SampleW-1:0] med_o
);

  logic [swm_pkg::SampleW-1:0] l1_d [swm_pkg::L1N];
  logic [swm_pkg::SampleW-1:0] l1_q [swm_pkg::L1N];
  logic [swm_pkg::SampleW-1:0] l2_d [swm_pkg::L2N];
  logic [swm_pkg::SampleW-1:0] l2_q [swm_pkg::L2N];

  always_comb begin
    for (int g = 0; g < swm_pkg::L1N; g++) begin
      l1_d[g] = '0;
      for (int j = 0; j < swm_pkg::Fan; j++) begin
        if (g * swm_pkg::Fan + j < swm_pkg::MaxWindow) begin
          l1_d[g] = l1_d[g] | tap_i[g * swm_pkg::Fan + j];
        end
      end
    end
  end

  always_comb begin
    for (int g = 0; g < swm_pkg::L2N; g++) begin
      l2_d[g] = '0;
      for (int j = 0; j < swm_pkg::Fan; j++) begin
        if (g * swm_pkg::Fan + j < swm_pkg::L1N) begin
          l2_d[g] = l2_d[g] | l1_q[g * swm_pkg::Fan + j];
        end
      end
    end
  end

  always_comb begin
    med_o = '0;
    for (int g = 0; g < swm_pkg::L2N; g++) begin
      med_o = med_o | l2_q[g];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      l1_q <= l1_d;
      l2_q <= l2_d;
    end
  end

endmodule

FILE: hdl/sliding_window_median_top.sv
// Sliding-window lower-median filter. Samples sit in a row of MaxWindow
// sorted cells; each beat removes the oldest sample (found from an arrival
// ring memory, read one beat ahead) and inserts the new one, every cell
// deciding locally from its two neighbors. One sample is accepted per clock
// while in_stall_o is low; the result passes the cell row, the registered
// select tree levels and the output register holding the saturating sum. A
// stall on the output holds the whole pipeline. Writing window_size restarts
// the sequence; it is accepted only while no beat is in flight (cfg_ready_o).
module sliding_window_median_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [swm_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [swm_pkg::SampleW-1:0] sample_i,
  input  logic                        last_sample_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        median_valid_o,
  output logic [swm_pkg::SampleW-1:0] median_o,
  output logic [swm_pkg::SumW-1:0]    median_sum_o,
  output logic                        sequence_end_o
);

  typedef struct packed {
    logic vld;
    logic last;
    logic mvld;
  } stg_t;

  logic [swm_pkg::CntW-1:0] weff_q, weff_d;
  logic [swm_pkg::IdxW-1:0] mid_q, mid_d;
  logic [swm_pkg::CntW-1:0] fill_q, fill_d;
  logic [swm_pkg::IdxW-1:0] ptr_q, ptr_d;
  logic [swm_pkg::SumW-1:0] acc_q;

  stg_t s0_q, s1_q, s2_q;
  logic out_vld_q;
  logic out_mvld_q;
  logic out_last_q;
  logic [swm_pkg::SampleW-1:0] out_med_q;
  logic [swm_pkg::SumW-1:0]    out_sum_q;

  logic [swm_pkg::SampleW-1:0] ring [swm_pkg::MaxWindow];
  logic [swm_pkg::SampleW-1:0] x_q;

  logic adv, accept, cfg_we, full, mvld;
  logic [swm_pkg::CntW-1:0] fill_after, ptr_ext;
  logic [swm_pkg::IdxW-1:0] ptr_next;

  swm_pkg::bcast_t             cmd;
  logic [swm_pkg::SampleW-1:0] taps [swm_pkg::MaxWindow];
  logic [swm_pkg::SampleW-1:0] tree_med;
  logic [swm_pkg::SampleW-1:0] med_gated;
  logic [swm_pkg::SumW:0]      sum_wide;
  logic [swm_pkg::SumW-1:0]    sum_sat;

  // A window write takes the edge; a sample offered at the same time waits.
  assign adv         = !(out_vld_q && out_stall_i);
  assign in_stall_o  = !adv || cfg_we;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = !(s0_q.vld || s1_q.vld || s2_q.vld || out_vld_q);
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // Window length clamps to 1..MaxWindow; the median rank follows from it.
  always_comb begin
    if (cfg_data_i == '0) begin
      weff_d = swm_pkg::CntW'(1);
    end else if (32'(cfg_data_i) > 32'(swm_pkg::MaxWindow)) begin
      weff_d = swm_pkg::CntW'(swm_pkg::MaxWindow);
    end else begin
      weff_d = swm_pkg::CntW'(cfg_data_i);
    end
    mid_d = swm_pkg::IdxW'((weff_d - swm_pkg::CntW'(1)) >> 1);
  end

  assign full       = (fill_q == weff_q);
  assign fill_after = full ? fill_q : fill_q + swm_pkg::CntW'(1);
  assign mvld       = (fill_after == weff_q);
  assign ptr_ext    = swm_pkg::CntW'(ptr_q) + swm_pkg::CntW'(1);
  assign ptr_next   = (ptr_ext == weff_q) ? '0 : ptr_ext[swm_pkg::IdxW-1:0];

  always_comb begin
    fill_d = fill_q;
    ptr_d  = ptr_q;
    if (cfg_we) begin
      fill_d = '0;
      ptr_d  = '0;
    end else if (accept) begin
      if (last_sample_i) begin
        fill_d = '0;
        ptr_d  = '0;
      end else begin
        fill_d = fill_after;
        ptr_d  = ptr_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weff_q <= swm_pkg::CntW'(swm_pkg::ResetWindow);
      mid_q  <= swm_pkg::IdxW'((swm_pkg::ResetWindow - 1) / 2);
      fill_q <= '0;
      ptr_q  <= '0;
    end else begin
      if (cfg_we) begin
        weff_q <= weff_d;
        mid_q  <= mid_d;
      end
      fill_q <= fill_d;
      ptr_q  <= ptr_d;
    end
  end

  // Arrival ring. The read address is the next pointer, so the departing
  // sample is ready when the next beat arrives; a same-slot write bypasses.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ring[ptr_q] <= sample_i;
    end
    if (accept && (ptr_d == ptr_q)) begin
      x_q <= sample_i;
    end else begin
      x_q <= ring[ptr_d];
    end
  end

  assign cmd.en     = accept;
  assign cmd.clr    = cfg_we || (accept && last_sample_i);
  assign cmd.full   = full;
  assign cmd.s_ge_x = (sample_i >= x_q);
  assign cmd.s      = sample_i;
  assign cmd.x      = x_q;

  swm_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .mid_i  (mid_q),
    .tap_o  (taps)
  );

  swm_tree u_tree (
    .clk_i (clk_i),
    .adv_i (adv),
    .tap_i (taps),
    .med_o (tree_med)
  );

  assign med_gated = s2_q.mvld ? tree_med : '0;
  assign sum_wide  = {1'b0, acc_q} + (swm_pkg::SumW + 1)'(med_gated);
  assign sum_sat   = sum_wide[swm_pkg::SumW] ? swm_pkg::SumMax
                                             : sum_wide[swm_pkg::SumW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q      <= '0;
      s1_q      <= '0;
      s2_q      <= '0;
      out_vld_q <= 1'b0;
      acc_q     <= '0;
    end else begin
      if (adv) begin
        s0_q.vld  <= accept;
        s0_q.last <= last_sample_i;
        s0_q.mvld <= mvld;
        s1_q      <= s0_q;
        s2_q      <= s1_q;
        out_vld_q <= s2_q.vld;
      end
      if (cfg_we) begin
        acc_q <= '0;
      end else if (adv && s2_q.vld) begin
        acc_q <= s2_q.last ? '0 : sum_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_q.vld) begin
      out_mvld_q <= s2_q.mvld;
      out_last_q <= s2_q.last;
      out_med_q  <= med_gated;
      out_sum_q  <= sum_sat;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign median_valid_o = out_mvld_q;
  assign median_o       = out_med_q;
  assign median_sum_o   = out_sum_q;
  assign sequence_end_o = out_last_q;

  a_fill_in_window : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= weff_q)
    else $error("fill count exceeds the window length");

  a_ptr_in_window : assert property (@(posedge clk_i) disable iff (!rst_ni)
    swm_pkg::CntW'(ptr_q) < weff_q)
    else $error("ring pointer outside the window");

  a_cfg_restarts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we |=> (fill_q == '0) && (ptr_q == '0) && (acc_q == '0))
    else $error("window write did not restart the sequence");

  a_full_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && full && !last_sample_i && !cfg_we) |=> (fill_q == $past(fill_q)))
    else $error("fill count moved while the window was full");

endmodule

FILE: tb/sv/sliding_window_median_top_tb.sv
`timescale 1ns / 100ps

module sliding_window_median_top_tb;

  typedef struct packed {
    logic                        median_valid;
    logic [swm_pkg::SampleW-1:0] median;
    logic [swm_pkg::SumW-1:0]    median_sum;
    logic                        sequence_end;
  } median_beat_t;

  typedef enum int {
    MIX_FULL,
    MIX_FEW,
    MIX_EXTREME,
    MIX_HIGH
  } sample_mix_e;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [swm_pkg::CfgW-1:0]    cfg_data_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic [swm_pkg::SampleW-1:0] sample_i = '0;
  logic                        last_sample_i = 1'b0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic                        median_valid_o;
  logic [swm_pkg::SampleW-1:0] median_o;
  logic [swm_pkg::SumW-1:0]    median_sum_o;
  logic                        sequence_end_o;

  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;

  // Shadow state of the filter, updated once per accepted input beat.
  logic [swm_pkg::CfgW-1:0]    window_reg = swm_pkg::CfgW'(swm_pkg::ResetWindow);
  logic [swm_pkg::SampleW-1:0] arrival_hist [swm_pkg::MaxWindow];
  logic [swm_pkg::SampleW-1:0] sorted_vals [$];
  int                          filled = 0;
  int                          oldest_ptr = 0;
  logic [swm_pkg::SumW-1:0]    median_total = '0;

  median_beat_t expected_medians [$];

  sliding_window_median_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_i      (sample_i),
    .last_sample_i (last_sample_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .median_valid_o(median_valid_o),
    .median_o      (median_o),
    .median_sum_o  (median_sum_o),
    .sequence_end_o(sequence_end_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic void restart_sequence();
    filled = 0;
    oldest_ptr = 0;
    median_total = '0;
    sorted_vals.delete();
  endfunction

  function automatic median_beat_t compute_median_beat(logic [swm_pkg::SampleW-1:0] s,
                                                       logic last);
    int               w;
    int               pos;
    longint unsigned  acc;
    median_beat_t     r;
    r = '0;
    if (window_reg == 0) w = 1;
    else if (window_reg > swm_pkg::MaxWindow) w = swm_pkg::MaxWindow;
    else w = int'(window_reg);

    if (filled > w) restart_sequence();
    if (oldest_ptr >= w) oldest_ptr = 0;

    if (filled < w) begin
      filled++;
    end else begin
      // Drop one copy of the oldest value; any equal entry leaves the same list.
      pos = 0;
      while (pos < sorted_vals.size() && sorted_vals[pos] != arrival_hist[oldest_ptr]) pos++;
      if (pos < sorted_vals.size()) sorted_vals.delete(pos);
    end
    // New sample lands after the entries equal to it.
    pos = 0;
    while (pos < sorted_vals.size() && sorted_vals[pos] <= s) pos++;
    sorted_vals.insert(pos, s);

    arrival_hist[oldest_ptr] = s;
    oldest_ptr++;
    if (oldest_ptr >= w) oldest_ptr = 0;

    if (filled == w) begin
      r.median_valid = 1'b1;
      r.median = sorted_vals[(w - 1) / 2];
      acc = longint'(median_total) + longint'(r.median);
      if (acc > longint'(swm_pkg::SumMax)) acc = longint'(swm_pkg::SumMax);
      median_total = acc[swm_pkg::SumW-1:0];
    end
    r.median_sum = median_total;
    r.sequence_end = last;
    if (last) restart_sequence();
    return r;
  endfunction

  function automatic logic [swm_pkg::SampleW-1:0] pick_sample(sample_mix_e mix);
    case (mix)
      MIX_FEW:     return swm_pkg::SampleW'($urandom_range(0, 3));
      MIX_EXTREME: return $urandom_range(0, 1) ? {swm_pkg::SampleW{1'b1}} : '0;
      MIX_HIGH:    return swm_pkg::SampleW'($urandom_range(65528, 65535));
      default:     return swm_pkg::SampleW'($urandom_range(0, 65535));
    endcase
  endfunction

  // Presents one sample and returns at the edge where the beat is taken.
  // Valid is left high so back-to-back beats need no extra step.
  task automatic send_sample(logic [swm_pkg::SampleW-1:0] s, logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i <= s;
    last_sample_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    expected_medians.insert(expected_medians.size(), compute_median_beat(s, last));
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_medians.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_window(logic [swm_pkg::CfgW-1:0] value);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    window_reg = value;
    restart_sequence();
  endtask

  task automatic test_directed_cases();
    // Reset window of three: extremes, then a run of equal samples.
    send_sample(16'd0, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'd7, 1'b0);
    send_sample(16'd7, 1'b0);
    send_sample(16'd7, 1'b1);
    // Sequence that ends before the window fills.
    send_sample(16'd5, 1'b0);
    send_sample(16'd5, 1'b1);
    // A zero window behaves as a window of one: the median is the sample.
    write_window('0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'd0, 1'b0);
    send_sample(16'd12345, 1'b1);
    write_window(swm_pkg::CfgW'(1));
    send_sample(16'd42, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    // Even window picks the lower of the two middle values.
    write_window(swm_pkg::CfgW'(2));
    send_sample(16'd10, 1'b0);
    send_sample(16'd20, 1'b0);
    send_sample(16'd5, 1'b0);
    send_sample(16'd20, 1'b0);
    send_sample(16'd20, 1'b1);
  endtask

  task automatic run_sequences(int n_items);
    int          sent;
    int          w;
    int          len;
    sample_mix_e mix;
    sent = 0;
    while (sent < n_items) begin
      if (window_reg == 0) w = 1;
      else if (window_reg > swm_pkg::MaxWindow) w = swm_pkg::MaxWindow;
      else w = int'(window_reg);
      // Mostly sequences that fill the window, some that end early.
      if ($urandom_range(99) < 80) len = $urandom_range(w, w + 24);
      else len = $urandom_range(1, w);
      if (len > n_items - sent) len = n_items - sent;
      mix = sample_mix_e'($urandom_range(0, 3));
      for (int i = 0; i < len; i++) begin
        send_sample(pick_sample(mix), i == len - 1);
      end
      sent += len;
    end
  endtask

  task automatic test_random_windows();
    int idle_tab [4];
    int stall_tab [4];
    idle_tab = '{0, 84, 0, 21};
    stall_tab = '{0, 0, 84, 21};
    for (int p = 0; p < 4; p++) begin
      for (int k = 0; k < 2; k++) begin
        // Settings change only while nothing is in flight.
        if ($urandom_range(99) < 70) write_window(swm_pkg::CfgW'($urandom_range(1, 9)));
        else write_window(swm_pkg::CfgW'($urandom_range(10, 48)));
        sender_idle_pct = idle_tab[p];
        recv_stall_pct = stall_tab[p];
        run_sequences(60);
      end
    end
    sender_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_large_windows();
    logic [swm_pkg::CfgW-1:0] sizes [3];
    sizes = '{swm_pkg::CfgW'(swm_pkg::MaxWindow), {swm_pkg::CfgW{1'b1}},
              swm_pkg::CfgW'(swm_pkg::MaxWindow + 1)};
    // Sizes at and above the bound saturate to it, so twenty samples never fill it.
    for (int k = 0; k < 3; k++) begin
      write_window(sizes[k]);
      for (int i = 0; i < 20; i++) begin
        send_sample(pick_sample(sample_mix_e'($urandom_range(0, 3))), i == 19);
      end
    end
  endtask

  always @(posedge clk_i) begin
    median_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_medians.size() == 0) begin
        $error("result beat with nothing expected: median %0d sum %0d", median_o,
               median_sum_o);
        error_count++;
      end else begin
        want = expected_medians.pop_front();
        if (median_valid_o !== want.median_valid) begin
          $error("median_valid: expected %0d, got %0d", want.median_valid, median_valid_o);
          error_count++;
        end
        if (median_o !== want.median) begin
          $error("median: expected %0d, got %0d", want.median, median_o);
          error_count++;
        end
        if (median_sum_o !== want.median_sum) begin
          $error("median_sum: expected %0d, got %0d", want.median_sum, median_sum_o);
          error_count++;
        end
        if (sequence_end_o !== want.sequence_end) begin
          $error("sequence_end: expected %0d, got %0d", want.sequence_end, sequence_end_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_random_windows();
    test_large_windows();
    drain_results();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/swm_pkg.sv
hdl/swm_cell.sv
hdl/swm_chain.sv
hdl/swm_tree.sv
hdl/sliding_window_median_top.sv
tb/sv/sliding_window_median_top_tb.sv
